FILE: design/bcx_pkg.sv
package bcx_pkg;

  // Opcode values of the instruction set.
  localparam logic [7:0] OP_SET  = 8'h01;
  localparam logic [7:0] OP_MOV  = 8'h02;
  localparam logic [7:0] OP_CLR  = 8'h03;
  localparam logic [7:0] OP_GET  = 8'h04;
  localparam logic [7:0] OP_STR  = 8'h05;
  localparam logic [7:0] OP_OUT  = 8'h06;
  localparam logic [7:0] OP_ROM  = 8'h07;
  localparam logic [7:0] OP_ADI  = 8'ha1;
  localparam logic [7:0] OP_ADD  = 8'ha2;
  localparam logic [7:0] OP_SUI  = 8'ha3;
  localparam logic [7:0] OP_SUB  = 8'ha4;
  localparam logic [7:0] OP_AND  = 8'ha5;
  localparam logic [7:0] OP_OR   = 8'ha6;
  localparam logic [7:0] OP_XOR  = 8'ha7;
  localparam logic [7:0] OP_NOT  = 8'ha8;
  localparam logic [7:0] OP_SHL  = 8'ha9;
  localparam logic [7:0] OP_SHR  = 8'haa;
  localparam logic [7:0] OP_LT   = 8'hab;
  localparam logic [7:0] OP_GT   = 8'hac;
  localparam logic [7:0] OP_EQ   = 8'had;
  localparam logic [7:0] OP_NE   = 8'hae;
  localparam logic [7:0] OP_NOP  = 8'hb1;
  localparam logic [7:0] OP_HLT  = 8'hb2;
  localparam logic [7:0] OP_JMP  = 8'hb3;
  localparam logic [7:0] OP_JEI  = 8'hb4;
  localparam logic [7:0] OP_JER  = 8'hb5;
  localparam logic [7:0] OP_JMPR = 8'hb6;
  localparam logic [7:0] OP_JMIR = 8'hb7;
  localparam logic [7:0] OP_JMRR = 8'hb8;
  localparam logic [7:0] OP_PUSH = 8'hc1;
  localparam logic [7:0] OP_POP  = 8'hc2;
  localparam logic [7:0] OP_CALL = 8'hc3;
  localparam logic [7:0] OP_RET  = 8'hc4;

  // The stack pointer register and the sequential PC step.
  localparam logic [7:0] SP_INDEX = 8'h07;
  localparam logic [7:0] PC_STEP  = 8'h04;

  // One result item.
  typedef struct packed {
    logic [7:0] next_pc;
    logic       running;
    logic       out_valid;
    logic [7:0] out_index;
    logic [7:0] out_value;
    logic       bad_opcode;
  } res_t;

  // Reduces a byte modulo d for 8 <= d <= 256 by restoring subtraction.
  function automatic logic [7:0] mod_byte(input logic [7:0] v, input int d);
    int t;
    t = int'(v);
    for (int k = 4; k >= 0; k--) begin
      if (t >= (d << k)) begin
        t = t - (d << k);
      end
    end
    return t[7:0];
  endfunction

  // Program image fixed at build: all zero.
  function automatic logic [7:0] rom_byte(input logic [7:0] addr);
    logic [7:0] q;
    q = 8'h00;
    if (addr == 8'h00) begin
      q = 8'h00;
    end
    return q;
  endfunction

endpackage

FILE: design/bcx_in_if.sv
interface bcx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] operation;
  logic [7:0] operand_a;
  logic [7:0] operand_b;
  logic [7:0] operand_c;

  modport source (output valid, operation, operand_a, operand_b, operand_c, input ready);
  modport sink   (input valid, operation, operand_a, operand_b, operand_c, output ready);
endinterface

FILE: design/bcx_out_if.sv
interface bcx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] next_pc;
  logic       running;
  logic       out_valid;
  logic [7:0] out_index;
  logic [7:0] out_value;
  logic       bad_opcode;

  modport source (output valid, next_pc, running, out_valid, out_index, out_value,
                  bad_opcode, input ready);
  modport sink   (input valid, next_pc, running, out_valid, out_index, out_value,
                  bad_opcode, output ready);
endinterface

FILE: design/byte_cpu_instruction_executor_unit.sv
// Channel | Direction | Contents
// in_ch   | sink      | operation, operand_a, operand_b, operand_c
// out_ch  | source    | next_pc, running, out_valid, out_index, out_value, bad_opcode
//
// Each item first reads the data RAM, then executes.
// A new item is accepted only once the held item has executed; in_ch.ready is low meanwhile.
// Reset (rst_n, synchronous) clears registers, PC and RAM written flags; running is set.
// A result waiting in the output register stalls execution; the held item then keeps
// in_ch.ready low until the result is taken.
module byte_cpu_instruction_executor_unit
  import bcx_pkg::*;
#(
  parameter int REG_COUNT = 8,
  parameter int RAM_DEPTH = 256,
  parameter int ROM_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  bcx_in_if.sink    in_ch,
  bcx_out_if.source out_ch
);

  localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int AW = $clog2(RAM_DEPTH);

  logic [7:0] rf_q [REG_COUNT];

  logic       s1_vld_r;
  logic [7:0] op_r, a_r, b_r, c_r, rom_addr_r;
  logic [7:0] pc_r, pc_nxt;
  logic       run_r, run_nxt;
  res_t       res_r, res_nxt;
  logic       res_vld_r;

  logic          accept, commit;
  logic [RW-1:0] rb0, ra, rb, rc, spi;
  logic [7:0]    sp0, rd_byte;
  logic [AW-1:0] rd_addr;
  logic          wa_en, sp_en, wr_en;
  logic [RW-1:0] wa_idx;
  logic [7:0]    wa_data, sp_data, wr_data, ram_q;
  logic [AW-1:0] wr_addr;

  assign spi    = SP_INDEX[RW-1:0];
  assign accept = in_ch.valid && in_ch.ready;
  assign commit = s1_vld_r && (!res_vld_r || out_ch.ready);
  assign in_ch.ready = !s1_vld_r;

  // Address phase: work out the RAM read address from the current registers.
  always_comb begin
    rb0 = RW'(mod_byte(in_ch.operand_b, REG_COUNT));
    sp0 = rf_q[spi];
    if (in_ch.operation == OP_POP || in_ch.operation == OP_RET) begin
      rd_byte = sp0 + 8'h01;
    end else begin
      rd_byte = rf_q[rb0] + in_ch.operand_c;
    end
    rd_addr = AW'(mod_byte(rd_byte, RAM_DEPTH));
  end

  // Item held for the execute phase.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= in_ch.operation;
      a_r        <= in_ch.operand_a;
      b_r        <= in_ch.operand_b;
      c_r        <= in_ch.operand_c;
      rom_addr_r <= mod_byte(rf_q[rb0] + in_ch.operand_c, ROM_DEPTH);
    end
  end

  bcx_data_ram #(.RAM_DEPTH(RAM_DEPTH), .AW(AW)) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (ram_q),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  bcx_reg_file #(.REG_COUNT(REG_COUNT), .RW(RW)) u_rf (
    .clk     (clk),
    .rst_n   (rst_n),
    .wa_en   (wa_en),
    .wa_idx  (wa_idx),
    .wa_data (wa_data),
    .sp_en   (sp_en),
    .sp_data (sp_data),
    .rf_q    (rf_q)
  );

  // Execute phase: decode, compute and prepare write-back and the result.
  always_comb begin
    logic [7:0] va, vb, vc, sp, stp;
    logic       wr_q;
    ra  = RW'(mod_byte(a_r, REG_COUNT));
    rb  = RW'(mod_byte(b_r, REG_COUNT));
    rc  = RW'(mod_byte(c_r, REG_COUNT));
    va  = rf_q[ra];
    vb  = rf_q[rb];
    vc  = rf_q[rc];
    sp  = rf_q[spi];
    stp = pc_r + PC_STEP;
    wr_q    = 1'b0;
    wa_en   = 1'b0;
    wa_idx  = rc;
    wa_data = 8'h00;
    sp_en   = 1'b0;
    sp_data = sp;
    wr_data = va;
    wr_addr = AW'(mod_byte(vb + c_r, RAM_DEPTH));
    pc_nxt  = stp;
    run_nxt = run_r;
    res_nxt = '0;
    if (run_r) begin
      case (op_r)
        OP_SET: begin wa_en = 1'b1; wa_idx = ra; wa_data = b_r; end
        OP_MOV: begin wa_en = 1'b1; wa_idx = rb; wa_data = va; end
        OP_CLR: begin wa_en = 1'b1; wa_idx = ra; wa_data = 8'h00; end
        OP_GET: begin wa_en = 1'b1; wa_idx = ra; wa_data = ram_q; end
        OP_STR: begin wr_q = 1'b1; end
        OP_OUT: begin
          res_nxt.out_valid = 1'b1;
          res_nxt.out_index = 8'(ra);
          res_nxt.out_value = va;
        end
        OP_ROM: begin wa_en = 1'b1; wa_idx = ra; wa_data = rom_byte(rom_addr_r); end
        OP_ADI: begin wa_en = 1'b1; wa_data = va + b_r; end
        OP_ADD: begin wa_en = 1'b1; wa_data = va + vb; end
        OP_SUI: begin wa_en = 1'b1; wa_data = va - b_r; end
        OP_SUB: begin wa_en = 1'b1; wa_data = va - vb; end
        OP_AND: begin wa_en = 1'b1; wa_data = va & vb; end
        OP_OR:  begin wa_en = 1'b1; wa_data = va | vb; end
        OP_XOR: begin wa_en = 1'b1; wa_data = va ^ vb; end
        OP_NOT: begin wa_en = 1'b1; wa_idx = rb; wa_data = ~va; end
        OP_SHL: begin wa_en = 1'b1; wa_data = (b_r >= 8'd8) ? 8'h00 : va << b_r[2:0]; end
        OP_SHR: begin wa_en = 1'b1; wa_data = (b_r >= 8'd8) ? 8'h00 : va >> b_r[2:0]; end
        OP_LT:  begin wa_en = 1'b1; wa_data = {7'd0, va < vb}; end
        OP_GT:  begin wa_en = 1'b1; wa_data = {7'd0, va > vb}; end
        OP_EQ:  begin wa_en = 1'b1; wa_data = {7'd0, va == vb}; end
        OP_NE:  begin wa_en = 1'b1; wa_data = {7'd0, va != vb}; end
        OP_NOP: begin end
        OP_HLT: begin run_nxt = 1'b0; pc_nxt = pc_r; end
        OP_JMP: begin pc_nxt = a_r; end
        OP_JEI: begin if (vb == c_r) pc_nxt = a_r; end
        OP_JER: begin if (vb == vc) pc_nxt = a_r; end
        OP_JMPR: begin pc_nxt = va; end
        OP_JMIR: begin if (vb == c_r) pc_nxt = va; end
        OP_JMRR: begin if (vb == vc) pc_nxt = va; end
        OP_PUSH: begin
          wr_q    = 1'b1;
          wr_addr = AW'(mod_byte(sp, RAM_DEPTH));
          sp_en   = 1'b1;
          sp_data = sp - 8'h01;
        end
        OP_POP: begin
          sp_en   = 1'b1;
          sp_data = sp + 8'h01;
          wa_en   = 1'b1;
          wa_idx  = ra;
          wa_data = ram_q;
        end
        OP_CALL: begin
          wr_q    = 1'b1;
          wr_addr = AW'(mod_byte(sp, RAM_DEPTH));
          wr_data = stp;
          sp_en   = 1'b1;
          sp_data = sp - 8'h01;
          pc_nxt  = a_r;
        end
        OP_RET: begin
          sp_en   = 1'b1;
          sp_data = sp + 8'h01;
          pc_nxt  = ram_q;
        end
        default: begin
          run_nxt = 1'b0;
          pc_nxt  = pc_r;
          res_nxt.bad_opcode = 1'b1;
        end
      endcase
    end else begin
      pc_nxt = pc_r;
    end
    res_nxt.next_pc = pc_nxt;
    res_nxt.running = run_nxt;
    wa_en = wa_en && commit;
    sp_en = sp_en && commit;
    wr_en = wr_q && commit;
  end

  // Control state: stage occupancy, PC, run flag and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      pc_r      <= 8'h00;
      run_r     <= 1'b1;
      res_vld_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_vld_r <= 1'b1;
      end else if (commit) begin
        s1_vld_r <= 1'b0;
      end
      if (commit) begin
        pc_r      <= pc_nxt;
        run_r     <= run_nxt;
        res_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (commit) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid      = res_vld_r;
  assign out_ch.next_pc    = res_r.next_pc;
  assign out_ch.running    = res_r.running;
  assign out_ch.out_valid  = res_r.out_valid;
  assign out_ch.out_index  = res_r.out_index;
  assign out_ch.out_value  = res_r.out_value;
  assign out_ch.bad_opcode = res_r.bad_opcode;

endmodule

FILE: design/bcx_data_ram.sv
module bcx_data_ram #(
  parameter int RAM_DEPTH = 256,
  parameter int AW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data
);

  logic [7:0]           mem [RAM_DEPTH];
  logic [RAM_DEPTH-1:0] vld_r;
  logic [7:0]           q_r;
  logic                 q_vld_r;

  // Storage array with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  // Written flags: an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        q_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = q_vld_r ? q_r : 8'h00;

endmodule

FILE: design/bcx_reg_file.sv
module bcx_reg_file
  import bcx_pkg::*;
#(
  parameter int REG_COUNT = 8,
  parameter int RW = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wa_en,
  input  logic [RW-1:0] wa_idx,
  input  logic [7:0]    wa_data,
  input  logic          sp_en,
  input  logic [7:0]    sp_data,
  output logic [7:0]    rf_q [REG_COUNT]
);

  logic [7:0] rf_r [REG_COUNT];
  logic       sp_wr;

  // The stack pointer port only writes when the indexed port leaves the stack pointer register alone.
  assign sp_wr = sp_en && !(wa_en && (wa_idx == SP_INDEX[RW-1:0]));

  // Two write ports; the indexed port wins over the stack pointer update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        rf_r[i] <= 8'h00;
      end
    end else begin
      if (sp_wr) begin
        rf_r[SP_INDEX[RW-1:0]] <= sp_data;
      end
      if (wa_en) begin
        rf_r[wa_idx] <= wa_data;
      end
    end
  end

  assign rf_q = rf_r;

endmodule
